// File: hw/rtl/point_transform_perspective_divide_macros.svh
// Assertion macros shared by the point transform RTL.
// Included by ptpd_div.sv and point_transform_perspective_divide.sv.
`ifndef POINT_TRANSFORM_PERSPECTIVE_DIVIDE_MACROS_SVH
`define POINT_TRANSFORM_PERSPECTIVE_DIVIDE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define PTPD_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("ptpd assertion failed");
// Next-cycle implication, disabled during reset.
`define PTPD_ASSERT_NXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("ptpd assertion failed");
`else
`define PTPD_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define PTPD_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

// File: hw/rtl/ptpd_pkg.sv
// Package for the point transform: register indexes, lane count and the
// side-band struct carried through the divider. No dependencies.
`timescale 1ns / 1ps
package ptpd_pkg;
	localparam int NUM_REGS  = 8;
	localparam int NUM_LANES = 3;

	// Register indexes (byte address is 8 * index)
	localparam logic [2:0] REG_C0R01 = 3'd0;
	localparam logic [2:0] REG_C0R23 = 3'd1;
	localparam logic [2:0] REG_C1R01 = 3'd2;
	localparam logic [2:0] REG_C1R23 = 3'd3;
	localparam logic [2:0] REG_C2R01 = 3'd4;
	localparam logic [2:0] REG_C2R23 = 3'd5;
	localparam logic [2:0] REG_C3R01 = 3'd6;
	localparam logic [2:0] REG_C3R23 = 3'd7;

	// Data that rides along with the quotient pipeline
	typedef struct packed {
		logic [NUM_LANES-1:0][31:0] res;  // saturated sums x, y, z
		logic [NUM_LANES-1:0]       neg;  // quotient sign per lane
		logic                       div;  // division applies
		logic                       sat;  // a sum was clamped
	} side_t;
endpackage

// File: hw/rtl/ptpd_div.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor. Depends on ptpd_pkg and the macros header.
`timescale 1ns / 1ps
`include "point_transform_perspective_divide_macros.svh"
module ptpd_div #(
	parameter int ND = 48
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 vld_in,
	input  logic [ptpd_pkg::NUM_LANES-1:0][ND-1:0] num_in,
	input  logic [31:0]                          den_in,
	input  ptpd_pkg::side_t                      side_in,
	output logic                                 vld_out,
	output logic [ptpd_pkg::NUM_LANES-1:0][ND-1:0] quo_out,
	output ptpd_pkg::side_t                      side_out
);
	import ptpd_pkg::*;

	logic                            vld_q  [ND];
	logic [NUM_LANES-1:0][ND-1:0]    num_q  [ND];
	logic [NUM_LANES-1:0][ND-1:0]    quo_q  [ND];
	logic [NUM_LANES-1:0][31:0]      rem_q  [ND];
	logic [31:0]                     den_q  [ND];
	side_t                           side_q [ND];

	for (genvar k = 0; k < ND; k++) begin : g_stage
		logic                         v_i;
		logic [NUM_LANES-1:0][ND-1:0] n_i;
		logic [NUM_LANES-1:0][ND-1:0] q_i;
		logic [NUM_LANES-1:0][31:0]   r_i;
		logic [31:0]                  d_i;
		side_t                        s_i;
		logic [NUM_LANES-1:0][ND-1:0] n_nx;
		logic [NUM_LANES-1:0][ND-1:0] q_nx;
		logic [NUM_LANES-1:0][31:0]   r_nx;

		// Select stage input: ports for the first stage, else previous stage
		if (k == 0) begin : g_first
			assign v_i = vld_in;
			assign n_i = num_in;
			assign q_i = '0;
			assign r_i = '0;
			assign d_i = den_in;
			assign s_i = side_in;
		end else begin : g_next
			assign v_i = vld_q[k-1];
			assign n_i = num_q[k-1];
			assign q_i = quo_q[k-1];
			assign r_i = rem_q[k-1];
			assign d_i = den_q[k-1];
			assign s_i = side_q[k-1];
		end

		// Shift in one dividend bit and try to subtract the divisor
		always_comb begin
			logic [32:0] r_sh;
			logic        ge;
			for (int l = 0; l < NUM_LANES; l++) begin
				r_sh    = {r_i[l], n_i[l][ND-1]};
				ge      = (r_sh >= {1'b0, d_i});
				r_nx[l] = ge ? 32'(r_sh - {1'b0, d_i}) : r_sh[31:0];
				q_nx[l] = {q_i[l][ND-2:0], ge};
				n_nx[l] = {n_i[l][ND-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_q[k]  <= n_nx;
				quo_q[k]  <= q_nx;
				rem_q[k]  <= r_nx;
				den_q[k]  <= d_i;
				side_q[k] <= s_i;
			end
		end
	end

	assign vld_out  = vld_q[ND-1];
	assign quo_out  = quo_q[ND-1];
	assign side_out = side_q[ND-1];

	`PTPD_ASSERT_IMP(a_den_nonzero, clk, arst_n, vld_q[ND-1], den_q[ND-1] != 32'd0)
	`PTPD_ASSERT_IMP(a_rem_x_lt_den, clk, arst_n, vld_q[ND-1], rem_q[ND-1][0] < den_q[ND-1])
	`PTPD_ASSERT_IMP(a_rem_z_lt_den, clk, arst_n, vld_q[ND-1], rem_q[ND-1][2] < den_q[ND-1])
endmodule

// File: hw/rtl/point_transform_perspective_divide.sv
// Homogeneous 4x4 point transform with perspective divide, top level.
// Depends on ptpd_pkg, ptpd_div and the macros header.
//
// Usage: one point (x, y, z, signed fixed point) enters per s_ transaction;
// one result (x, y, z, divided, saturated) leaves per m_ transaction.
// The matrix sits in eight 64-bit registers on the APB port, two entries
// each, at byte addresses 0, 8, ... 56; write them only while idle.
// Throughput: one point per cycle while the receiver does not stall, set by
// the fully pipelined multipliers and the divider, which resolves one
// quotient bit per stage. From input transaction to output valid a point
// passes four arithmetic stages, 32 + FRAC_BITS divider stages and the
// output register; the first stage loads at the accepting edge.
// Reset loads the identity matrix and empties the pipeline.
// When the receiver stalls, the whole pipeline holds and s_tready drops
// once the output register is full; nothing is lost or repeated.
// The divide applies when the cut w is neither zero nor one; quotients
// truncate toward zero and clamp to the signed 32-bit range.
`timescale 1ns / 1ps
`include "point_transform_perspective_divide_macros.svh"
module point_transform_perspective_divide #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // in_x[31:0], in_y[63:32], in_z[95:64]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // out_x[31:0], out_y[63:32], out_z[95:64]
	output logic [1:0]  m_tuser,   // divided[0], saturated[1]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import ptpd_pkg::*;

	localparam int          ND      = 32 + FRAC_BITS;
	localparam int          SW      = 66;
	localparam logic [31:0] ONE_FIX = 32'd1 << FRAC_BITS;
	localparam logic signed [SW-1:0] S32_MAX = SW'(64'sh7fffffff);
	localparam logic signed [SW-1:0] S32_MIN = -SW'(64'sh80000000);

	logic [63:0]        mat_q [NUM_REGS];
	logic signed [31:0] m [4][4];
	logic               cfg_wr;
	logic               adv;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = mat_q[paddr[5:3]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[REG_C0R01] <= {32'd0, ONE_FIX};
			mat_q[REG_C0R23] <= '0;
			mat_q[REG_C1R01] <= {ONE_FIX, 32'd0};
			mat_q[REG_C1R23] <= '0;
			mat_q[REG_C2R01] <= '0;
			mat_q[REG_C2R23] <= {32'd0, ONE_FIX};
			mat_q[REG_C3R01] <= '0;
			mat_q[REG_C3R23] <= {ONE_FIX, 32'd0};
		end else if (cfg_wr) begin
			mat_q[paddr[5:3]] <= pwdata;
		end
	end

	// Unpack entries m[col][row]
	always_comb begin
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				m[c][r] = mat_q[c*2 + r/2][(r%2)*32 +: 32];
	end

	// Advance the whole pipeline unless the output register is blocked
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// Stage 1: twelve products and the translation column
	logic               vld_s1;
	logic signed [63:0] prod_s1 [4][3];
	logic signed [31:0] tr_s1 [4];
	logic signed [31:0] pin [3];

	always_comb begin
		for (int c = 0; c < 3; c++) pin[c] = s_tdata[c*32 +: 32];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 3; c++) prod_s1[r][c] <= m[c][r] * pin[c];
				tr_s1[r] <= m[3][r];
			end
		end
	end

	// Stage 2: full-width row sums
	logic               vld_s2;
	logic signed [SW-1:0] sum_s2 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++)
				sum_s2[r] <= SW'(prod_s1[r][0]) + SW'(prod_s1[r][1]) + SW'(prod_s1[r][2])
					+ (SW'(tr_s1[r]) <<< FRAC_BITS);
		end
	end

	// Stage 3: cut to the point format and clamp
	logic               vld_s3;
	logic signed [31:0] res_s3 [4];
	logic               sat_s3;

	always_ff @(posedge clk) begin
		logic signed [SW-1:0] sh;
		logic                 any;
		if (adv) begin
			any = 1'b0;
			for (int r = 0; r < 4; r++) begin
				sh = sum_s2[r] >>> FRAC_BITS;
				if (sh > S32_MAX) begin
					res_s3[r] <= 32'sh7fffffff;
					any = 1'b1;
				end else if (sh < S32_MIN) begin
					res_s3[r] <= 32'sh80000000;
					any = 1'b1;
				end else begin
					res_s3[r] <= 32'(sh);
				end
			end
			sat_s3 <= any;
		end
	end

	// Stage 4: divide decision, magnitudes and signs
	logic                         vld_s4;
	logic [NUM_LANES-1:0][ND-1:0] nmag_s4;
	logic [31:0]                  dmag_s4;
	side_t                        side_s4;

	always_ff @(posedge clk) begin
		logic [32:0] ext;
		logic [31:0] mag;
		logic        dv;
		if (adv) begin
			dv  = (res_s3[3] != 32'sd0) && (res_s3[3] != signed'(ONE_FIX));
			ext = {res_s3[3][31], res_s3[3]};
			mag = res_s3[3][31] ? 32'(-ext) : 32'(ext);
			dmag_s4 <= dv ? mag : 32'd1;
			for (int l = 0; l < NUM_LANES; l++) begin
				ext = {res_s3[l][31], res_s3[l]};
				mag = res_s3[l][31] ? 32'(-ext) : 32'(ext);
				nmag_s4[l]     <= ND'(mag) << FRAC_BITS;
				side_s4.res[l] <= res_s3[l];
				side_s4.neg[l] <= res_s3[l][31] ^ res_s3[3][31];
			end
			side_s4.div <= dv;
			side_s4.sat <= sat_s3;
		end
	end

	// Valid bits for the arithmetic stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Quotient pipeline
	logic                         dv_vld;
	logic [NUM_LANES-1:0][ND-1:0] dv_quo;
	side_t                        dv_side;

	ptpd_div #(
		.ND(ND)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s4),
		.num_in   (nmag_s4),
		.den_in   (dmag_s4),
		.side_in  (side_s4),
		.vld_out  (dv_vld),
		.quo_out  (dv_quo),
		.side_out (dv_side)
	);

	// Output register: apply sign, clamp quotients, select result
	logic        vld_q;
	logic [95:0] data_q;
	logic [1:0]  user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		logic any;
		if (adv) begin
			any = dv_side.sat;
			for (int l = 0; l < NUM_LANES; l++) begin
				if (!dv_side.div) begin
					data_q[l*32 +: 32] <= dv_side.res[l];
				end else if (dv_side.neg[l]) begin
					if (dv_quo[l] > ND'(64'h80000000)) begin
						data_q[l*32 +: 32] <= 32'h80000000;
						any = 1'b1;
					end else begin
						data_q[l*32 +: 32] <= 32'(-dv_quo[l]);
					end
				end else begin
					if (dv_quo[l] > ND'(64'h7fffffff)) begin
						data_q[l*32 +: 32] <= 32'h7fffffff;
						any = 1'b1;
					end else begin
						data_q[l*32 +: 32] <= 32'(dv_quo[l]);
					end
				end
			end
			user_q <= {any, dv_side.div};
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

	`PTPD_ASSERT_IMP(a_stall_only_blocked, clk, arst_n, !s_tready, m_tvalid && !m_tready)
	`PTPD_ASSERT_NXT(a_no_div_zero_w, clk, arst_n,
		adv && vld_s3 && (res_s3[3] == 32'sd0), !side_s4.div)
	`PTPD_ASSERT_NXT(a_no_div_unit_w, clk, arst_n,
		adv && vld_s3 && (res_s3[3] == signed'(ONE_FIX)), dmag_s4 == 32'd1)
endmodule
